@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the rgb convolution core
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RCV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen
`define RCV_NEVER(label, expr, msg) \
    `RCV_ASSERT(label, !(expr), msg)

`endif

@@ rtl/rcv_pkg.sv @@
// shared constants, codes and types of the rgb convolution core
// no dependencies
`default_nettype none

package rcv_pkg;

    localparam int MAX_KERNEL   = 5;
    localparam int CHANNELS     = 3;
    localparam int SAMPLE_W     = 8;
    localparam int PIX_W        = SAMPLE_W * CHANNELS;
    localparam int NCOEF        = MAX_KERNEL * MAX_KERNEL;
    localparam int BANK_W       = $clog2(MAX_KERNEL);
    localparam int KSZ_W        = 3;
    localparam int FRM_W        = 11;
    localparam int GEO_W        = 13;
    localparam int ROW_W        = 11;
    localparam int POS_W        = 24;
    localparam int MAX_ROWS     = 1024;
    localparam int COEF_W       = 16;
    localparam int CIDX_W       = 5;
    localparam int FRAC_BITS    = 12;
    localparam int MQ_DEPTH     = 4;
    localparam int OUT_DEPTH    = 8;
    localparam int DEF_MAX_LINE = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRM_W;

    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd3;

    localparam logic [KSZ_W-1:0] RST_KERNEL = 3'd3;
    localparam logic [FRM_W-1:0] RST_FRAME  = 11'd1024;

    // clamped geometry as used by the datapath
    typedef struct packed {
        logic [KSZ_W-1:0] kw;
        logic [KSZ_W-1:0] kh;
        logic [GEO_W-1:0] fw;
        logic [GEO_W-1:0] fh;
        logic [KSZ_W-1:0] offr;
        logic [KSZ_W-1:0] offc;
    } t_geom;

    typedef logic [MAX_KERNEL-1:0][PIX_W-1:0] t_col;

    // one beat from the front end to the arithmetic back end
    typedef struct packed {
        logic                     is_coef;
        logic [CIDX_W-1:0]        cidx;
        logic signed [COEF_W-1:0] cval;
        t_col                     col;
        logic                     out;
        logic                     fe;
        logic [GEO_W-1:0]         ocol;
    } t_beat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

@@ rtl/rcv_front.sv @@
// front end: raster tracking, line store banks and column assembly
// depends on rcv_pkg and assert_macros.svh
`default_nettype none

module rcv_front #(
    parameter int MAX_LINE = rcv_pkg::DEF_MAX_LINE
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  rcv_pkg::t_geom                i_geom,
    input  wire                           i_restart,
    input  wire                           i_push,
    output logic                          o_full,
    input  wire  [1:0]                    i_mode,
    input  wire  [rcv_pkg::CIDX_W-1:0]    i_coef_index,
    input  wire  signed [rcv_pkg::COEF_W-1:0] i_coef_value,
    input  wire  [rcv_pkg::SAMPLE_W-1:0]  i_red_in,
    input  wire  [rcv_pkg::SAMPLE_W-1:0]  i_green_in,
    input  wire  [rcv_pkg::SAMPLE_W-1:0]  i_blue_in,
    input  rcv_pkg::t_qstat               i_q_stat,
    output logic                          o_q_push,
    output rcv_pkg::t_beat                o_beat
);
    import rcv_pkg::*;
    `include "assert_macros.svh"

    localparam int COL_W = $clog2(MAX_LINE);

    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [POS_W-1:0]  r_pos;
    logic [COL_W-1:0]  r_ocol;
    logic [BANK_W-1:0] r_bank;

    logic                     r_fv;
    logic                     r_is_coef;
    logic [CIDX_W-1:0]        r_cidx;
    logic signed [COEF_W-1:0] r_cval;
    logic [PIX_W-1:0]         r_px;
    logic [MAX_KERNEL-1:0]    r_rmask;
    logic [BANK_W-1:0]        r_sbank;
    logic                     r_out;
    logic                     r_fe;
    logic [COL_W-1:0]         r_socol;
    logic [PIX_W-1:0]         r_rd [MAX_KERNEL];

    logic [POS_W-1:0]      w_lag;
    logic [POS_W-1:0]      w_total;
    logic [POS_W-1:0]      w_last;
    logic                  w_acc;
    logic                  w_take_px;
    logic                  w_take_coef;
    logic                  w_in_frame;
    logic                  w_out;
    logic                  w_fe;
    logic                  w_col_last;
    logic                  w_ocol_last;
    logic [PIX_W-1:0]      w_px;
    logic [MAX_KERNEL-1:0] w_rmask;
    logic                  w_adv;
    t_col                  w_col;

    assign w_lag   = POS_W'(i_geom.offr) * POS_W'(i_geom.fw) + POS_W'(i_geom.offc);
    assign w_total = POS_W'(i_geom.fw) * POS_W'(i_geom.fh);
    assign w_last  = w_lag + w_total - POS_W'(1);

    assign w_adv       = r_fv && !i_q_stat.full;
    assign o_full      = r_fv && i_q_stat.full;
    assign w_acc       = i_push && !o_full;
    assign w_take_px   = (i_mode == MODE_PIXEL) || (i_mode == MODE_FLUSH);
    assign w_take_coef = (i_mode == MODE_COEF) && (32'(i_coef_index) < NCOEF);
    assign w_in_frame  = (GEO_W'(r_in_row) < i_geom.fh) && (GEO_W'(r_in_col) < i_geom.fw);
    assign w_out       = r_pos >= w_lag;
    assign w_fe        = w_out && (r_pos == w_last);
    assign w_col_last  = GEO_W'(r_in_col) == (i_geom.fw - GEO_W'(1));
    assign w_ocol_last = GEO_W'(r_ocol) == (i_geom.fw - GEO_W'(1));
    assign w_px        = (i_mode == MODE_PIXEL) ? {i_blue_in, i_green_in, i_red_in} : '0;

    // rows of the entering column, newest first, zero outside the frame
    always_comb begin
        for (int r = 0; r < MAX_KERNEL; r++) begin
            w_rmask[r] = (ROW_W'(r) <= r_in_row)
                      && (GEO_W'(r_in_row - ROW_W'(r)) < i_geom.fh)
                      && (r < int'(i_geom.kh));
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_pos    <= '0;
            r_ocol   <= '0;
            r_bank   <= '0;
        end else if (w_acc && w_take_px) begin
            if (w_fe) begin
                r_in_col <= '0;
                r_in_row <= '0;
                r_pos    <= '0;
                r_ocol   <= '0;
                r_bank   <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
                if (w_col_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                    r_bank   <= (r_bank == BANK_W'(MAX_KERNEL - 1)) ? '0 : r_bank + BANK_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (w_out) begin
                    r_ocol <= w_ocol_last ? '0 : r_ocol + COL_W'(1);
                end
            end
        end
    end

    // one bank per ring row, current row written while the older rows are read
    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        logic [PIX_W-1:0] mem [MAX_LINE];
        always_ff @(posedge i_clk) begin
            if (w_acc && w_take_px && w_in_frame && (r_bank == BANK_W'(b))) begin
                mem[r_in_col] <= w_px;
            end
            if (w_acc && w_take_px) begin
                r_rd[b] <= mem[r_in_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc && (w_take_px || w_take_coef)) begin
            r_fv <= 1'b1;
        end else if (w_adv) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_is_coef <= !w_take_px;
            r_cidx    <= i_coef_index;
            r_cval    <= i_coef_value;
            r_px      <= w_px;
            r_rmask   <= w_rmask;
            r_sbank   <= r_bank;
            r_out     <= w_out;
            r_fe      <= w_fe;
            r_socol   <= r_ocol;
        end
    end

    // rotate bank data into row order
    always_comb begin
        logic [BANK_W:0] bi;
        bi = '0;
        for (int r = 0; r < MAX_KERNEL; r++) begin
            if (r == 0) begin
                w_col[r] = r_rmask[0] ? r_px : '0;
            end else begin
                bi = {1'b0, r_sbank} + (BANK_W+1)'(MAX_KERNEL - r);
                if (bi >= (BANK_W+1)'(MAX_KERNEL)) begin
                    bi = bi - (BANK_W+1)'(MAX_KERNEL);
                end
                w_col[r] = r_rmask[r] ? r_rd[bi[BANK_W-1:0]] : '0;
            end
        end
    end

    assign o_q_push     = w_adv;
    assign o_beat.is_coef = r_is_coef;
    assign o_beat.cidx  = r_cidx;
    assign o_beat.cval  = r_cval;
    assign o_beat.col   = w_col;
    assign o_beat.out   = r_out && !r_is_coef;
    assign o_beat.fe    = r_fe && !r_is_coef;
    assign o_beat.ocol  = GEO_W'(r_socol);

    `RCV_NEVER(a_fe_without_out, r_fv && !r_is_coef && r_fe && !r_out,
        "frame end flagged on a position that gives no result")

endmodule

`default_nettype wire

@@ rtl/rcv_queue.sv @@
// short beat queue between front and back end
// depends on rcv_pkg and assert_macros.svh
`default_nettype none

module rcv_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  rcv_pkg::t_beat  i_beat,
    input  wire             i_pop,
    output rcv_pkg::t_beat  o_beat,
    output rcv_pkg::t_qstat o_stat
);
    import rcv_pkg::*;
    `include "assert_macros.svh"

    localparam int QA_W = $clog2(MQ_DEPTH);

    t_beat           r_mem [MQ_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QA_W'(1);
            end
            r_cnt <= r_cnt + (QA_W+1)'(i_push) - (QA_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    assign o_beat       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (QA_W+1)'(MQ_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    `RCV_NEVER(a_mq_overflow, i_push && o_stat.full && !i_pop, "beat pushed into a full queue")
    `RCV_NEVER(a_mq_underflow, i_pop && o_stat.empty, "beat popped from an empty queue")

endmodule

`default_nettype wire

@@ rtl/rcv_back.sv @@
// back end: coefficient store, window, multiply, sum, round and result queue
// depends on rcv_pkg and assert_macros.svh
`default_nettype none

module rcv_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  rcv_pkg::t_geom               i_geom,
    input  rcv_pkg::t_beat               i_beat,
    input  rcv_pkg::t_qstat              i_q_stat,
    output logic                         o_q_pop,
    input  wire                          i_pop,
    output logic                         o_empty,
    output logic [rcv_pkg::SAMPLE_W-1:0] o_red_out,
    output logic [rcv_pkg::SAMPLE_W-1:0] o_green_out,
    output logic [rcv_pkg::SAMPLE_W-1:0] o_blue_out,
    output logic                         o_frame_end
);
    import rcv_pkg::*;
    `include "assert_macros.svh"

    localparam int PROD_W = SAMPLE_W + 1 + COEF_W;
    localparam int RSUM_W = PROD_W + $clog2(MAX_KERNEL) + 1;
    localparam int TOT_W  = RSUM_W + $clog2(MAX_KERNEL) + 1;
    localparam int CR_W   = $clog2(OUT_DEPTH + 1);
    localparam int OA_W   = $clog2(OUT_DEPTH);
    localparam int RES_W  = PIX_W + 1;
    localparam int SAT    = (1 << SAMPLE_W) - 1;

    logic signed [COEF_W-1:0] r_coef [NCOEF];
    t_col                     r_win [MAX_KERNEL];
    logic [CR_W-1:0]          r_credit;

    logic             r_b0v, r_b1v, r_b2v;
    logic             r_b0_fe, r_b1_fe, r_b2_fe;
    logic [GEO_W-1:0] r_b0_ocol;

    logic signed [PROD_W-1:0] r_prod [CHANNELS][MAX_KERNEL][MAX_KERNEL];
    logic signed [RSUM_W-1:0] r_rsum [CHANNELS][MAX_KERNEL];

    logic [RES_W-1:0] r_ofifo [OUT_DEPTH];
    logic [OA_W-1:0]  r_owp, r_orp;
    logic [CR_W-1:0]  r_ocnt;

    logic                     w_pop;
    logic                     w_opop;
    logic [MAX_KERNEL-1:0]    w_cok;
    logic signed [PROD_W-1:0] w_prod [CHANNELS][MAX_KERNEL][MAX_KERNEL];
    logic [PIX_W-1:0]         w_res;

    assign w_pop   = !i_q_stat.empty && (r_credit < CR_W'(OUT_DEPTH));
    assign o_q_pop = w_pop;
    assign w_opop  = i_pop && !o_empty;

    // a beat is taken only while the result queue has room for its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CR_W'(w_pop && i_beat.out) - CR_W'(w_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_pop && i_beat.is_coef) begin
            r_coef[i_beat.cidx] <= i_beat.cval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !i_beat.is_coef) begin
            r_win[0] <= i_beat.col;
            for (int c = 1; c < MAX_KERNEL; c++) begin
                r_win[c] <= r_win[c-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0v <= 1'b0;
            r_b1v <= 1'b0;
            r_b2v <= 1'b0;
        end else begin
            r_b0v <= w_pop && i_beat.out;
            r_b1v <= r_b0v;
            r_b2v <= r_b1v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0_ocol <= i_beat.ocol;
        r_b0_fe   <= i_beat.fe;
        r_b1_fe   <= r_b0_fe;
        r_b2_fe   <= r_b1_fe;
    end

    // window column c is image column ocol + offc - c, zero outside the frame
    always_comb begin
        logic [GEO_W:0] t;
        t = {1'b0, r_b0_ocol} + (GEO_W+1)'(i_geom.offc);
        for (int c = 0; c < MAX_KERNEL; c++) begin
            w_cok[c] = (c < int'(i_geom.kw)) && (t >= (GEO_W+1)'(c))
                    && ((t - (GEO_W+1)'(c)) < {1'b0, i_geom.fw});
        end
    end

    always_comb begin
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] k;
        a = '0;
        k = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int r = 0; r < MAX_KERNEL; r++) begin
                for (int c = 0; c < MAX_KERNEL; c++) begin
                    a = PROD_W'($signed({1'b0, r_win[c][r][ch*SAMPLE_W +: SAMPLE_W]}));
                    k = PROD_W'(r_coef[r*MAX_KERNEL + c]);
                    w_prod[ch][r][c] = w_cok[c] ? a * k : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int r = 0; r < MAX_KERNEL; r++) begin
                logic signed [RSUM_W-1:0] s;
                s = '0;
                for (int c = 0; c < MAX_KERNEL; c++) begin
                    s = s + RSUM_W'(r_prod[ch][r][c]);
                end
                r_rsum[ch][r] <= s;
            end
        end
    end

    // round half up, then saturate
    always_comb begin
        logic signed [TOT_W-1:0] tot;
        tot = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            tot = TOT_W'(1 << (FRAC_BITS - 1));
            for (int r = 0; r < MAX_KERNEL; r++) begin
                tot = tot + TOT_W'(r_rsum[ch][r]);
            end
            if (tot < 0) begin
                w_res[ch*SAMPLE_W +: SAMPLE_W] = '0;
            end else if ((tot >>> FRAC_BITS) > SAT) begin
                w_res[ch*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(SAT);
            end else begin
                w_res[ch*SAMPLE_W +: SAMPLE_W] = tot[FRAC_BITS +: SAMPLE_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_b2v) begin
                r_owp <= r_owp + OA_W'(1);
            end
            if (w_opop) begin
                r_orp <= r_orp + OA_W'(1);
            end
            r_ocnt <= r_ocnt + CR_W'(r_b2v) - CR_W'(w_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b2v) begin
            r_ofifo[r_owp] <= {r_b2_fe, w_res};
        end
    end

    assign o_empty     = r_ocnt == '0;
    assign o_red_out   = r_ofifo[r_orp][0 +: SAMPLE_W];
    assign o_green_out = r_ofifo[r_orp][SAMPLE_W +: SAMPLE_W];
    assign o_blue_out  = r_ofifo[r_orp][2*SAMPLE_W +: SAMPLE_W];
    assign o_frame_end = r_ofifo[r_orp][PIX_W];

    `RCV_NEVER(a_credit_bound, r_credit > CR_W'(OUT_DEPTH), "result credit beyond queue depth")
    `RCV_NEVER(a_result_overflow, r_b2v && !w_opop && (r_ocnt == CR_W'(OUT_DEPTH)),
        "result written into a full result queue")
    `RCV_ASSERT(a_credit_covers, r_ocnt <= r_credit, "results queued without credit")

endmodule

`default_nettype wire

@@ rtl/rgb_convolution_2d_core.sv @@
// top level of the streaming rgb 2d convolution core
// depends on rcv_pkg, rcv_front, rcv_queue and rcv_back
`default_nettype none

// Streams rgb pixels in raster order and filters each channel with one flipped kernel of up
// to 5x5 signed Q4.12 coefficients, padding with zeros outside the frame, rounding half up
// and saturating to 0..255. The core takes one item per clock and returns one result per
// clock when both sides keep moving; the line store is one memory bank per kernel row, so
// the current row is written and the older rows are read in the same cycle. A pixel's
// result leaves (kernel_height/2)*frame_width + kernel_width/2 positions later, which flush
// items supply at the frame end; on its way to the result ports it passes the front
// register, the beat queue, the window, the multiply stage and the row-sum stage, whose
// final sum and rounding write the result queue. The back end takes a beat only while the
// eight-deep result queue has room, so a stalled reader fills the beat queue and then
// holds off the input. Coefficient loads travel the same path, so they take effect in
// item order. Any configuration write restarts the frame.
module rgb_convolution_2d_core #(
    parameter int MAX_LINE = rcv_pkg::DEF_MAX_LINE
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [rcv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [rcv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                              i_push,
    output logic                             o_full,
    input  wire  [1:0]                       i_mode,
    input  wire  [rcv_pkg::CIDX_W-1:0]       i_coef_index,
    input  wire  signed [rcv_pkg::COEF_W-1:0] i_coef_value,
    input  wire  [rcv_pkg::SAMPLE_W-1:0]     i_red_in,
    input  wire  [rcv_pkg::SAMPLE_W-1:0]     i_green_in,
    input  wire  [rcv_pkg::SAMPLE_W-1:0]     i_blue_in,
    output logic                             o_empty,
    input  wire                              i_pop,
    output logic [rcv_pkg::SAMPLE_W-1:0]     o_red_out,
    output logic [rcv_pkg::SAMPLE_W-1:0]     o_green_out,
    output logic [rcv_pkg::SAMPLE_W-1:0]     o_blue_out,
    output logic                             o_frame_end
);
    import rcv_pkg::*;

    logic [KSZ_W-1:0] r_kw;
    logic [KSZ_W-1:0] r_kh;
    logic [FRM_W-1:0] r_fw;
    logic [FRM_W-1:0] r_fh;

    t_geom  w_geom;
    t_beat  w_fbeat;
    t_beat  w_qbeat;
    t_qstat w_qstat;
    logic   w_qpush;
    logic   w_qpop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw <= RST_KERNEL;
            r_kh <= RST_KERNEL;
            r_fw <= RST_FRAME;
            r_fh <= RST_FRAME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KERNEL_WIDTH:  r_kw <= i_cfg_data[KSZ_W-1:0];
                CFG_KERNEL_HEIGHT: r_kh <= i_cfg_data[KSZ_W-1:0];
                CFG_FRAME_WIDTH:   r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the geometry to what the datapath holds
    always_comb begin
        w_geom.kw = (r_kw == '0) ? KSZ_W'(1) :
                    (32'(r_kw) > MAX_KERNEL) ? KSZ_W'(MAX_KERNEL) : r_kw;
        w_geom.kh = (r_kh == '0) ? KSZ_W'(1) :
                    (32'(r_kh) > MAX_KERNEL) ? KSZ_W'(MAX_KERNEL) : r_kh;
        w_geom.fw = (r_fw == '0) ? GEO_W'(1) :
                    (32'(r_fw) > MAX_LINE) ? GEO_W'(MAX_LINE) : GEO_W'(r_fw);
        w_geom.fh = (r_fh == '0) ? GEO_W'(1) :
                    (32'(r_fh) > MAX_ROWS) ? GEO_W'(MAX_ROWS) : GEO_W'(r_fh);
        w_geom.offr = w_geom.kh >> 1;
        w_geom.offc = w_geom.kw >> 1;
    end

    rcv_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (w_geom),
        .i_restart    (i_cfg_we),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_q_stat     (w_qstat),
        .o_q_push     (w_qpush),
        .o_beat       (w_fbeat)
    );

    rcv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_beat  (w_fbeat),
        .i_pop   (w_qpop),
        .o_beat  (w_qbeat),
        .o_stat  (w_qstat)
    );

    rcv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (w_geom),
        .i_beat      (w_qbeat),
        .i_q_stat    (w_qstat),
        .o_q_pop     (w_qpop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

@@ tb/tb_rgb_convolution_2d_core.sv @@
// self-checking testbench of the rgb 2d convolution core: random and directed frames
// against a behavioural predictor kept in the bench; depends on rcv_pkg and the core
`timescale 1ns / 100ps
`default_nettype none

module tb_rgb_convolution_2d_core;
    import rcv_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RING_ROWS = 2 * MAX_KERNEL;
    localparam int LINE_LEN  = DEF_MAX_LINE;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [1:0]         mode;
        logic [4:0]         idx;
        logic signed [15:0] val;
        logic [7:0]         r, g, b;
    } t_item;

    typedef struct {
        logic [7:0] r, g, b;
        logic       fe;
    } t_pixel_out;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_push, o_full, o_empty, i_pop;
    logic [1:0] i_mode;
    logic [CIDX_W-1:0] i_coef_index;
    logic signed [COEF_W-1:0] i_coef_value;
    logic [7:0] i_red_in, i_green_in, i_blue_in;
    logic [7:0] o_red_out, o_green_out, o_blue_out;
    logic o_frame_end;

    rgb_convolution_2d_core uut (.*);

    // predictor state
    int unsigned        reg_kw, reg_kh, reg_fw, reg_fh;
    logic signed [15:0] kcoef [NCOEF];
    logic [23:0]        line_mem [RING_ROWS*LINE_LEN];
    int unsigned        in_row, in_col, out_row, out_col;

    t_pixel_out filtered_q [$];
    int  mismatches;
    int  items_sent;
    bit  quiet;
    int  hold_cycles;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_rgb_convolution_2d_core failed");
        $finish;
    end

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic restart_frame();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    endtask

    task automatic predict_filter(t_item it);
        int unsigned kw, kh, fw, fh, offr, offc, lag, pos, total, q;
        int y, x;
        longint acc [3];
        longint v;
        logic [23:0] px;
        t_pixel_out res;
        if (it.mode == MODE_COEF) begin
            if (it.idx < NCOEF) kcoef[it.idx] = it.val;
            return;
        end
        if (it.mode == MODE_UNUSED) return;
        kw = clampu(reg_kw, 1, MAX_KERNEL);
        kh = clampu(reg_kh, 1, MAX_KERNEL);
        fw = clampu(reg_fw, 1, LINE_LEN);
        fh = clampu(reg_fh, 1, MAX_ROWS);
        offr = kh / 2; offc = kw / 2;
        lag = offr * fw + offc;
        total = fw * fh;
        if (in_row < fh && in_col < fw)
            line_mem[(in_row % RING_ROWS) * LINE_LEN + in_col] =
                (it.mode == MODE_PIXEL) ? {it.b, it.g, it.r} : 24'd0;
        pos = in_row * fw + in_col;
        in_col++;
        if (in_col >= fw) begin
            in_col = 0; in_row++;
        end
        if (pos < lag) return;
        q = pos - lag;
        acc[0] = 0; acc[1] = 0; acc[2] = 0;
        for (int r = 0; r < kh; r++) begin
            y = int'(out_row) - r + int'(offr);
            if (y < 0 || y >= int'(fh)) continue;
            for (int c = 0; c < kw; c++) begin
                x = int'(out_col) - c + int'(offc);
                if (x < 0 || x >= int'(fw)) continue;
                px = line_mem[(y % RING_ROWS) * LINE_LEN + x];
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(px[8*ch +: 8]) * longint'(kcoef[r*MAX_KERNEL + c]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            v = (acc[ch] + 2048) >>> FRAC_BITS;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            acc[ch] = v;
        end
        res.r = acc[0][7:0]; res.g = acc[1][7:0]; res.b = acc[2][7:0];
        res.fe = (q == total - 1);
        filtered_q.push_back(res);
        if (res.fe) restart_frame();
        else begin
            out_col++;
            if (out_col >= fw) begin
                out_col = 0; out_row++;
            end
        end
    endtask

    // one input beat; returns at a falling edge with push still high
    task automatic send_item(t_item it, bit burst = 0);
        int gap;
        gap = (burst || quiet) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_push = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode = it.mode; i_coef_index = it.idx; i_coef_value = it.val;
        i_red_in = it.r; i_green_in = it.g; i_blue_in = it.b;
        i_push = 1;
        forever begin
            @(posedge i_clk);
            if (!o_full) break;
        end
        predict_filter(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_push = 0;
        while (filtered_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        wait_drained();
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = data[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 0;
        case (idx)
            CFG_KERNEL_WIDTH:  reg_kw = data & 7;
            CFG_KERNEL_HEIGHT: reg_kh = data & 7;
            CFG_FRAME_WIDTH:   reg_fw = data & 'h7FF;
            default:           reg_fh = data & 'h7FF;
        endcase
        restart_frame();
    endtask

    task automatic set_geometry(int unsigned kw, int unsigned kh, int unsigned fw,
                                int unsigned fh);
        write_reg(CFG_KERNEL_WIDTH, kw);
        write_reg(CFG_KERNEL_HEIGHT, kh);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
    endtask

    function automatic t_item coef_item(int idx, int val);
        t_item it;
        it = '{MODE_COEF, idx[4:0], val[15:0], 8'd0, 8'd0, 8'd0};
        return it;
    endfunction

    function automatic t_item pixel_item(logic [1:0] mode);
        t_item it;
        it = '{mode, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        return it;
    endfunction

    function automatic int rand_coef();
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 1800)) - 600;
    endfunction

    task automatic load_kernel(bit burst = 0);
        for (int i = 0; i < NCOEF; i++) send_item(coef_item(i, rand_coef()), burst);
    endtask

    // a whole frame plus trailing positions, with some noise mixed in when noisy is set
    task automatic run_frame(bit noisy, bit burst = 0);
        int unsigned kw, kh, fw, fh, n;
        t_item it;
        kw = clampu(reg_kw, 1, MAX_KERNEL);
        kh = clampu(reg_kh, 1, MAX_KERNEL);
        fw = clampu(reg_fw, 1, LINE_LEN);
        fh = clampu(reg_fh, 1, MAX_ROWS);
        n = fw * fh + (kh / 2) * fw + kw / 2;
        for (int unsigned p = 0; p < n; p++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                it = pixel_item($urandom_range(0, 1) ? MODE_UNUSED : MODE_COEF);
                if (it.mode == MODE_COEF) it.val = rand_coef();
                send_item(it, burst);
            end
            if (p >= fw * fh)
                it = pixel_item($urandom_range(0, 3) == 0 ? MODE_PIXEL : MODE_FLUSH);
            else
                it = pixel_item(noisy && $urandom_range(0, 9) == 0 ? MODE_FLUSH : MODE_PIXEL);
            send_item(it, burst);
        end
    endtask

    task automatic test_directed();
        t_item it;
        // reset geometry: a few pixels, no output yet
        for (int i = 0; i < 4; i++) send_item(pixel_item(MODE_PIXEL));
        set_geometry(3, 3, 4, 3);
        send_item(coef_item(4, 16'sh1000));
        send_item(coef_item(0, -32768));
        send_item(coef_item(24, 32767));
        send_item(coef_item(31, 12345));   // out of range index, ignored
        send_item(coef_item(25, -1));
        it = pixel_item(MODE_UNUSED);
        send_item(it);
        for (int i = 0; i < 12; i++) begin
            it = pixel_item(i == 5 ? MODE_FLUSH : MODE_PIXEL);
            it.r = (i % 2) ? 8'hFF : 8'h00;
            it.g = (i % 3) ? 8'hFF : 8'h00;
            it.b = 8'hFF - it.r;
            send_item(it);
        end
        send_item(pixel_item(MODE_PIXEL));  // outside the frame: not stored
        for (int i = 0; i < 4; i++) send_item(pixel_item(MODE_FLUSH));
    endtask

    task automatic test_geometry_extremes();
        set_geometry(1, 1, 2047, 1);  // width clamped to a full 1024-pixel row
        send_item(coef_item(0, 16'sh1000));
        run_frame(0);
        set_geometry(5, 5, 1, 40);
        load_kernel();
        run_frame(0);
        set_geometry(0, 7, 9, 0);  // clamped to 1x5, 9x1
        run_frame(0);
        set_geometry(6, 0, 0, 2);
        run_frame(1);
        set_geometry(5, 5, 1, 1);
        run_frame(0);
    endtask

    task automatic test_random_frames();
        while (items_sent < 1600) begin
            set_geometry($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5),
                         $urandom_range(1, 16), $urandom_range(1, 8));
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) load_kernel();
            run_frame(1);
            quiet = 0;
        end
    endtask

    task automatic test_backpressure();
        set_geometry(3, 3, 8, 8);
        hold_cycles = 200;
        load_kernel(1);
        run_frame(0, 1);
        wait_drained();
        run_frame(1);
    endtask

    // result side
    initial begin
        int gap;
        t_pixel_out want;
        i_pop = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_pop = 0;
                while (hold_cycles > 0) begin
                    @(negedge i_clk);
                    hold_cycles--;
                end
            end
            gap = quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_pop = 0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop = 1;
            forever begin
                @(posedge i_clk);
                if (!o_empty) break;
            end
            if (filtered_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: r=%0d g=%0d b=%0d fe=%0b",
                             o_red_out, o_green_out, o_blue_out, o_frame_end);
            end else begin
                want = filtered_q.pop_front();
                if (o_red_out !== want.r || o_green_out !== want.g ||
                    o_blue_out !== want.b || o_frame_end !== want.fe) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected r=%0d g=%0d b=%0d fe=%0b, got r=%0d g=%0d b=%0d fe=%0b",
                                 want.r, want.g, want.b, want.fe,
                                 o_red_out, o_green_out, o_blue_out, o_frame_end);
                end
            end
        end
    end

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        i_push = 0; i_mode = '0; i_coef_index = '0; i_coef_value = '0;
        i_red_in = '0; i_green_in = '0; i_blue_in = '0;
        mismatches = 0; items_sent = 0; quiet = 0; hold_cycles = 0;
        reg_kw = 3; reg_kh = 3; reg_fw = 1024; reg_fh = 1024;
        foreach (kcoef[i]) kcoef[i] = '0;
        foreach (line_mem[i]) line_mem[i] = '0;
        restart_frame();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_geometry_extremes();
        test_backpressure();
        test_random_frames();
        wait_drained();
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("tb_rgb_convolution_2d_core passed");
        else
            $display("tb_rgb_convolution_2d_core failed");
        $finish;
    end

endmodule

`default_nettype wire
